// File: rtl/bf_pkg.sv
// ----------------------------------------------------------------------------
// bf_pkg
// Shared types, constants and helpers for the bloom filter with FNV hashing.
// ----------------------------------------------------------------------------
package bf_pkg;

	localparam int unsigned BITS_MAX   = 1048576;
	localparam int unsigned HASHES_MAX = 16;

	localparam int unsigned NB_W   = 21;
	localparam int unsigned NH_W   = $clog2(HASHES_MAX) + 1;
	localparam int unsigned POS_W  = $clog2(BITS_MAX);
	localparam int unsigned M_W    = POS_W + 1;
	localparam int unsigned HASH_W = 64;

	localparam int unsigned ROW_W    = 64;
	localparam int unsigned ROW_BITS = $clog2(ROW_W);
	localparam int unsigned ROWS     = BITS_MAX / ROW_W;
	localparam int unsigned ROW_AW   = POS_W - ROW_BITS;

	localparam int unsigned MOD_STEP  = 4;
	localparam int unsigned MOD_CYC   = HASH_W / MOD_STEP;
	localparam int unsigned MOD_CNT_W = $clog2(MOD_CYC);

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	localparam int unsigned CFG_AW = 4;
	localparam logic [CFG_AW-1:0] CFG_NUM_BITS   = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] CFG_NUM_HASHES = CFG_AW'(1);

	localparam logic [NB_W-1:0] RST_NUM_BITS   = NB_W'(1048576);
	localparam logic [NH_W-1:0] RST_NUM_HASHES = NH_W'(7);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

	typedef struct packed {
		logic              op;
		logic [HASH_W-1:0] h1;
		logic [HASH_W-1:0] h2;
	} bf_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} bf_q_status_t;

	typedef struct packed {
		logic           clearing;
		logic           access;
		logic [M_W-1:0] pos;
		logic [M_W-1:0] modulus;
	} bf_back_status_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_MOD,
		B_SETUP,
		B_RD,
		B_WR,
		B_DONE
	} bf_back_state_t;

	// multiply by the 64-bit FNV prime, 2^40 + 0x1b3
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
		fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [HASH_W-1:0] sext8(input logic [7:0] c);
		sext8 = {{(HASH_W-8){c[7]}}, c};
	endfunction

	function automatic logic [M_W-1:0] eff_bits(input logic [NB_W-1:0] nb);
		logic [M_W-1:0] m;
		if (nb == '0) begin
			m = M_W'(1);
		end else if (nb > NB_W'(BITS_MAX)) begin
			m = M_W'(BITS_MAX);
		end else begin
			m = M_W'(nb);
		end
		eff_bits = m;
	endfunction

	function automatic logic [NH_W-1:0] eff_hashes(input logic [NH_W-1:0] nh);
		eff_hashes = (nh > NH_W'(HASHES_MAX)) ? NH_W'(HASHES_MAX) : nh;
	endfunction

endpackage

// File: rtl/bf_front.sv
// ----------------------------------------------------------------------------
// bf_front
// Character intake: running FNV-1 and FNV-1a hashes, word hand-off to queue.
// ----------------------------------------------------------------------------
module bf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // char_code
	input  logic [1:0]           s_tuser,  // operation, has_char
	input  logic                 s_tlast,
	input  bf_pkg::bf_q_status_t q_st,
	output logic                 push,
	output bf_pkg::bf_word_t     push_word
);
	import bf_pkg::*;

	logic [HASH_W-1:0] h1_q, h2_q;
	logic [HASH_W-1:0] h1_nx, h2_nx, ext;
	logic              accept;

	assign s_tready = en && !q_st.full;
	assign accept   = s_tvalid && s_tready;
	assign ext      = sext8(s_tdata);

	always_comb begin
		if (s_tuser[1]) begin
			h1_nx = fnv_mul(h1_q) ^ ext;
			h2_nx = fnv_mul(h2_q ^ ext);
		end else begin
			h1_nx = h1_q;
			h2_nx = h2_q;
		end
	end

	assign push         = accept && s_tlast;
	assign push_word.op = s_tuser[0];
	assign push_word.h1 = h1_nx;
	assign push_word.h2 = h2_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h1_q <= FNV_BASIS;
			h2_q <= FNV_BASIS;
		end else if (accept) begin
			if (s_tlast) begin
				h1_q <= FNV_BASIS;
				h2_q <= FNV_BASIS;
			end else begin
				h1_q <= h1_nx;
				h2_q <= h2_nx;
			end
		end
	end

endmodule

// File: rtl/bf_fifo.sv
// ----------------------------------------------------------------------------
// bf_fifo
// Short word queue between the hashing front and the filter back end.
// ----------------------------------------------------------------------------
module bf_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bf_pkg::bf_word_t     push_data,
	input  logic                 pop,
	output bf_pkg::bf_word_t     pop_data,
	output bf_pkg::bf_q_status_t st
);
	import bf_pkg::*;

	bf_word_t        entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;

	assign st.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign st.empty = (cnt_q == '0);
	assign pop_data = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/bf_mod.sv
// ----------------------------------------------------------------------------
// bf_mod
// Iterative remainder of a 64-bit value by the filter size, a few bits a cycle.
// ----------------------------------------------------------------------------
module bf_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bf_pkg::HASH_W-1:0] dividend,
	input  logic [bf_pkg::M_W-1:0]    modulus,
	output logic                      busy,
	output logic [bf_pkg::M_W-1:0]    rem
);
	import bf_pkg::*;

	logic [HASH_W-1:0]    val_q;
	logic [M_W-1:0]       mod_q, rem_q, rem_nx;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [M_W-1:0]       r;
	logic [M_W:0]         t;

	assign busy = busy_q;
	assign rem  = rem_q;

	always_comb begin
		r = rem_q;
		t = '0;
		for (int j = 0; j < MOD_STEP; j++) begin
			t = {r, val_q[HASH_W-1-j]};
			if (t >= {1'b0, mod_q}) begin
				t = t - {1'b0, mod_q};
			end
			r = t[M_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= dividend;
			mod_q <= modulus;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << MOD_STEP;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MOD_CNT_W'(MOD_CYC-1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/bf_back.sv
// ----------------------------------------------------------------------------
// bf_back
// Word end processing: position derivation, bit store update and membership.
// ----------------------------------------------------------------------------
module bf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bf_pkg::bf_q_status_t        q_st,
	input  bf_pkg::bf_word_t            q_data,
	output logic                        pop,
	input  logic [bf_pkg::NB_W-1:0]     num_bits,
	input  logic [bf_pkg::NH_W-1:0]     num_hashes,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // present
	output bf_pkg::bf_back_status_t     st
);
	import bf_pkg::*;

	bf_back_state_t state_q, state_d;

	logic [ROW_W-1:0]  store_q [ROWS];
	logic [ROW_W-1:0]  rdata_q;
	logic [ROW_AW-1:0] clr_cnt_q;

	logic              op_q, carry_q, all_set_q, m_tvalid_q;
	logic [HASH_W-1:0] s_q, h2_q;
	logic [M_W-1:0]    m_q, r_q, h2m_q, r64_q, t1_q;
	logic [NH_W-1:0]   k_q, i_q;
	logic [7:0]        m_tdata_q;

	logic [2:0]        mod_busy;
	logic [M_W-1:0]    rem [3];
	logic              mod_start;

	logic              mem_we, mem_re, load_out, out_free, last_pos, cur_bit;
	logic [ROW_AW-1:0] mem_wa, mem_ra;
	logic [ROW_W-1:0]  mem_wd;
	logic [M_W-1:0]    r64_nx, t1_nx, r_nx, r64_inc;
	logic [M_W:0]      t1_sum;
	logic [HASH_W:0]   s_sum;
	logic [M_W-1:0]    m_eff;

	assign m_eff = eff_bits(num_bits);

	bf_mod u_mod_h1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (q_data.h1),
		.modulus  (m_eff),
		.busy     (mod_busy[0]),
		.rem      (rem[0])
	);

	bf_mod u_mod_h2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (q_data.h2),
		.modulus  (m_eff),
		.busy     (mod_busy[1]),
		.rem      (rem[1])
	);

	// 2^64 - 1 mod m, turned into 2^64 mod m at setup
	bf_mod u_mod_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend ('1),
		.modulus  (m_eff),
		.busy     (mod_busy[2]),
		.rem      (rem[2])
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign last_pos = (NH_W'(i_q + 1'b1) == k_q);
	assign cur_bit  = rdata_q[r_q[ROW_BITS-1:0]];

	// datapath arithmetic
	always_comb begin
		r64_inc = M_W'(rem[2] + 1'b1);
		r64_nx  = (r64_inc == m_q) ? '0 : r64_inc;
		t1_sum  = {1'b0, r_q} + {1'b0, h2m_q};
		t1_nx   = (t1_sum >= {1'b0, m_q}) ? M_W'(t1_sum - {1'b0, m_q}) : M_W'(t1_sum);
		s_sum   = {1'b0, s_q} + {1'b0, h2_q};
		if (!carry_q) begin
			r_nx = t1_q;
		end else if (t1_q >= r64_q) begin
			r_nx = t1_q - r64_q;
		end else begin
			r_nx = M_W'({1'b0, t1_q} + {1'b0, m_q} - {1'b0, r64_q});
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: begin
				if (clr_cnt_q == ROW_AW'(ROWS-1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_st.empty) begin
					state_d = B_MOD;
				end
			end
			B_MOD: begin
				if (mod_busy == '0) begin
					state_d = B_SETUP;
				end
			end
			B_SETUP: begin
				if (k_q != '0) begin
					state_d = B_RD;
				end else if (op_q == OP_CHECK) begin
					state_d = B_DONE;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_RD: state_d = B_WR;
			B_WR: begin
				if (!last_pos) begin
					state_d = B_RD;
				end else if (op_q == OP_CHECK) begin
					state_d = B_DONE;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_DONE: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = (state_q == B_IDLE) && !q_st.empty;
		mod_start = pop;
		mem_re    = (state_q == B_RD);
		mem_ra    = r_q[POS_W-1:ROW_BITS];
		load_out  = (state_q == B_DONE) && out_free;
		if (state_q == B_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end else begin
			mem_we = (state_q == B_WR) && (op_q == OP_INSERT);
			mem_wa = r_q[POS_W-1:ROW_BITS];
			mem_wd = rdata_q | (ROW_W'(1) << r_q[ROW_BITS-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= store_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!q_st.empty) begin
					op_q <= q_data.op;
					s_q  <= q_data.h1;
					h2_q <= q_data.h2;
					m_q  <= m_eff;
					k_q  <= eff_hashes(num_hashes);
				end
			end
			B_SETUP: begin
				r_q       <= rem[0];
				h2m_q     <= rem[1];
				r64_q     <= r64_nx;
				i_q       <= '0;
				all_set_q <= 1'b1;
			end
			B_RD: begin
				s_q     <= s_sum[HASH_W-1:0];
				carry_q <= s_sum[HASH_W];
				t1_q    <= t1_nx;
			end
			B_WR: begin
				r_q <= r_nx;
				i_q <= NH_W'(i_q + 1'b1);
				if (op_q == OP_CHECK) begin
					all_set_q <= all_set_q & cur_bit;
				end
			end
			B_DONE: begin
				if (load_out) begin
					m_tdata_q <= {7'b0, all_set_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;
	assign st.clearing = (state_q == B_CLEAR);
	assign st.access   = (state_q == B_WR);
	assign st.pos      = r_q;
	assign st.modulus  = m_q;

endmodule

// File: rtl/bloom_filter_fnv_double_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash
// Bloom filter over words streamed one character at a time, FNV double hashing.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata char_code, tuser operation/has_char,
//                                     tlast last_char
// m_*       out  m_tvalid/m_tready    tdata present (check answers only)
// cfg_*     in   cfg_valid/cfg_ready  cfg_addr register index, cfg_data value
//
// one character per cycle through the hash front while the word queue is not full;
// a word end costs the back end a pass through the remainder units, a setup
// step, a store read and then a store write or test per derived position,
// and for a check a hand-off of the answer to the output register
// after reset a clearing pass over all 16384 store rows (one row per cycle)
// holds s_tready low; cfg_ready stays high
// a two-entry word queue lets the front keep taking characters while the back
// works or waits on m_tready
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // char_code
	input  logic [1:0]                s_tuser,   // operation, has_char
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,   // present
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bf_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [bf_pkg::NB_W-1:0]   cfg_data
);
	import bf_pkg::*;

	logic [NB_W-1:0] num_bits_q;
	logic [NH_W-1:0] num_hashes_q;

	bf_q_status_t    q_st;
	bf_back_status_t bk_st;
	bf_word_t        push_word, pop_word;
	logic            push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bits_q   <= RST_NUM_BITS;
			num_hashes_q <= RST_NUM_HASHES;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_NUM_BITS:   num_bits_q   <= cfg_data;
				CFG_NUM_HASHES: num_hashes_q <= cfg_data[NH_W-1:0];
				default: ;
			endcase
		end
	end

	bf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (!bk_st.clearing),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_st      (q_st),
		.push      (push),
		.push_word (push_word)
	);

	bf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_word),
		.pop       (pop),
		.pop_data  (pop_word),
		.st        (q_st)
	);

	bf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_st       (q_st),
		.q_data     (pop_word),
		.pop        (pop),
		.num_bits   (num_bits_q),
		.num_hashes (num_hashes_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.st         (bk_st)
	);

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bk_st.access |-> (bk_st.pos < bk_st.modulus))
		else $error("derived position not below filter size");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |-> !q_st.full)
		else $error("word pushed into a full queue");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		bk_st.clearing |-> (q_st.empty && !m_tvalid))
		else $error("activity during store clearing pass");
`endif

endmodule

// File: tb/bloom_filter_fnv_double_hash_tb.sv
// ----------------------------------------------------------------------------
// bloom_filter_fnv_double_hash_tb
// Drives words one character per request into the filter, mixing inserts,
// repeat checks of inserted words, checks of fresh words and stray requests,
// under several filter sizes and hash counts. A local FNV-1/FNV-1a double
// hashing filter or a pinned value predicts each check answer, in order.
// ----------------------------------------------------------------------------
module bloom_filter_fnv_double_hash_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 70000;
	localparam int unsigned SETTLE_CYCLES  = 300;
	localparam int unsigned ITEM_TARGET    = 1300;
	localparam int unsigned QUIET_FROM     = 1100;
	localparam int unsigned PHASE_ITEMS    = 130;
	localparam int unsigned POOL_MAX       = 32;
	localparam int unsigned NB_MAX_FIELD   = (1 << bf_pkg::NB_W) - 1;

	localparam logic [63:0] OFFSET_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] HASH_MULT    = 64'h00000100000001B3;

	typedef struct packed {
		logic       op;
		logic [7:0] code;
		logic       has;
		logic       last;
		logic       pinned;
		logic       pinned_val;
	} stim_row_t;

	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] chars;
	} word_t;

	localparam int DIR_ROWS = 20;

	stim_row_t directed_rows [DIR_ROWS] = '{
		'{bf_pkg::OP_CHECK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
		'{bf_pkg::OP_CHECK,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
		'{bf_pkg::OP_INSERT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b1},
		'{bf_pkg::OP_CHECK,  8'hA5, 1'b0, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h7F, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_INSERT, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_INSERT, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
		'{bf_pkg::OP_INSERT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_INSERT, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h7F, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
		'{bf_pkg::OP_INSERT, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
		'{bf_pkg::OP_INSERT, 8'h12, 1'b0, 1'b1, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
		'{bf_pkg::OP_CHECK,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b0}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [7:0]                s_tdata = '0;   // char_code
	logic [1:0]                s_tuser = '0;   // operation, has_char
	logic                      s_tlast = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [7:0]                m_tdata;        // present
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [bf_pkg::CFG_AW-1:0] cfg_addr = '0;
	logic [bf_pkg::NB_W-1:0]   cfg_data = '0;

	logic s_pinned = 1'b0;
	logic s_pinned_val = 1'b0;

	logic [63:0]             run_h1 = OFFSET_BASIS;
	logic [63:0]             run_h2 = OFFSET_BASIS;
	logic [bf_pkg::NB_W-1:0] nbits_mirror = bf_pkg::NB_W'(1048576);
	logic [4:0]              nhash_mirror = 5'd7;
	bit                      filter_bits [bf_pkg::BITS_MAX];
	logic                    present_due [$];
	logic                    present_want;

	word_t       word_pool [$];
	int unsigned items_sent = 0;
	int unsigned fail_count = 0;
	int unsigned stall_cycles = 0;
	bit          gaps_on = 1'b1;
	bit          quiet = 1'b0;

	bloom_filter_fnv_double_hash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void absorb_char(input logic [7:0] c);
		logic [63:0] ext;
		ext = {{56{c[7]}}, c};
		run_h1 = (run_h1 * HASH_MULT) ^ ext;
		run_h2 = (run_h2 ^ ext) * HASH_MULT;
	endfunction

	function automatic void close_word(input logic op, input logic pinned,
			input logic pinned_val);
		logic [63:0] modulus;
		logic [63:0] probes;
		logic [63:0] pos;
		logic [63:0] idx;
		logic        all_set;
		modulus = (nbits_mirror == '0) ? 64'd1 :
			(nbits_mirror > bf_pkg::NB_W'(bf_pkg::BITS_MAX)) ? 64'(bf_pkg::BITS_MAX) :
			64'(nbits_mirror);
		probes = (nhash_mirror > 5'(bf_pkg::HASHES_MAX)) ? 64'(bf_pkg::HASHES_MAX) :
			64'(nhash_mirror);
		all_set = 1'b1;
		for (idx = 0; idx < probes; idx++) begin
			pos = (run_h1 + idx * run_h2) % modulus;
			if (op == bf_pkg::OP_INSERT) begin
				filter_bits[pos] = 1'b1;
			end else if (!filter_bits[pos]) begin
				all_set = 1'b0;
			end
		end
		run_h1 = OFFSET_BASIS;
		run_h2 = OFFSET_BASIS;
		if (op == bf_pkg::OP_CHECK) begin
			present_due = {present_due, (pinned ? pinned_val : all_set)};
		end
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (present_due.size() == 0) begin
				$error("present: expected none, actual %0d", m_tdata[0]);
				fail_count++;
			end else begin
				present_want = present_due.pop_front();
				if (m_tdata[0] !== present_want) begin
					$error("present: expected %0d, actual %0d", present_want, m_tdata[0]);
					fail_count++;
				end
			end
		end
		if (cfg_valid && cfg_ready) begin
			if (cfg_addr == bf_pkg::CFG_NUM_BITS) begin
				nbits_mirror = cfg_data;
			end else if (cfg_addr == bf_pkg::CFG_NUM_HASHES) begin
				nhash_mirror = cfg_data[4:0];
			end
		end
		if (s_tvalid && s_tready) begin
			if (s_tuser[1]) begin
				absorb_char(s_tdata);
			end
			if (s_tlast) begin
				close_word(s_tuser[0], s_pinned, s_pinned_val);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// receiver back-pressure
	always begin
		@(posedge clk);
		if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	task automatic send_item(input logic op, input logic [7:0] code, input logic has,
			input logic last, input logic pinned = 1'b0, input logic pinned_val = 1'b0);
		if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid     <= 1'b1;
		s_tdata      <= code;
		s_tuser      <= {has, op};
		s_tlast      <= last;
		s_pinned     <= pinned;
		s_pinned_val <= pinned_val;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (has || last) begin
			items_sent++;
		end
	endtask

	task automatic send_word(input word_t w, input logic op);
		logic tail_mark;
		logic is_end;
		int   j;
		tail_mark = (w.len != 0) && ($urandom_range(0, 9) == 0);
		if (w.len == 0) begin
			send_item(op, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
		for (j = 0; j < int'(w.len); j++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			is_end = (j == int'(w.len) - 1) && !tail_mark;
			send_item(is_end ? op : 1'($urandom_range(0, 1)), w.chars[8*j +: 8], 1'b1,
				is_end);
		end
		if (tail_mark) begin
			send_item(op, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	function automatic word_t random_word();
		word_t w;
		w.len   = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 6));
		w.chars = {$urandom, $urandom};
		return w;
	endfunction

	task automatic write_reg(input logic [bf_pkg::CFG_AW-1:0] addr,
			input logic [bf_pkg::NB_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [bf_pkg::NB_W-1:0] nb, input logic [4:0] nh);
		write_reg(bf_pkg::CFG_NUM_BITS, nb);
		write_reg(bf_pkg::CFG_NUM_HASHES, {16'($urandom_range(0, 65535)), nh});
		if ($urandom_range(0, 1) == 0) begin
			write_reg(bf_pkg::CFG_AW'($urandom_range(2, 15)),
				bf_pkg::NB_W'($urandom_range(0, NB_MAX_FIELD)));
		end
		cfg_valid <= 1'b0;
	endtask

	// hold the sender until every check answer is back and the back end is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (present_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned             phase;
		int unsigned             phase_end;
		int unsigned             choice;
		logic [bf_pkg::NB_W-1:0] nb;
		logic [4:0]              nh;
		word_t                   w;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(directed_rows[r].op, directed_rows[r].code, directed_rows[r].has,
				directed_rows[r].last, directed_rows[r].pinned, directed_rows[r].pinned_val);
		end
		settle();

		for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
			case (phase)
				0: begin
					nb = bf_pkg::NB_W'(1);
					nh = 5'd1;
				end
				1: begin
					nb = '0;
					nh = 5'd16;
				end
				2: begin
					nb = bf_pkg::NB_W'(NB_MAX_FIELD);
					nh = 5'd31;
				end
				3: begin
					nb = bf_pkg::NB_W'(8);
					nh = 5'd0;
				end
				4: begin
					nb = bf_pkg::NB_W'(bf_pkg::BITS_MAX);
					nh = 5'd16;
				end
				default: begin
					nb = ($urandom_range(0, 3) == 0) ?
						bf_pkg::NB_W'($urandom_range(0, NB_MAX_FIELD)) :
						bf_pkg::NB_W'($urandom_range(1, 64));
					nh = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
						5'($urandom_range(1, 16));
				end
			endcase
			apply_setting(nb, nh);
			gaps_on   = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				quiet  = (items_sent >= QUIET_FROM);
				choice = $urandom_range(0, 9);
				if (choice <= 3) begin
					w = random_word();
					send_word(w, bf_pkg::OP_INSERT);
					word_pool = {word_pool, w};
					if (word_pool.size() > POOL_MAX) begin
						void'(word_pool.pop_front());
					end
				end else if (choice <= 6 && word_pool.size() != 0) begin
					send_word(word_pool[$urandom_range(0, word_pool.size() - 1)],
						bf_pkg::OP_CHECK);
				end else if (choice <= 8) begin
					send_word(random_word(), bf_pkg::OP_CHECK);
				end else begin
					send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
			settle();
		end

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/bf_pkg.sv
rtl/bf_front.sv
rtl/bf_fifo.sv
rtl/bf_mod.sv
rtl/bf_back.sv
rtl/bloom_filter_fnv_double_hash.sv
tb/bloom_filter_fnv_double_hash_tb.sv
